FILE: hw/rtl/uart_tuning_command_parser_assert.svh
// Assertion macros used by the checker file of the tuning command parser.
`ifndef UART_TUNING_COMMAND_PARSER_ASSERT_SVH
`define UART_TUNING_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UTCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UTCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/utcp_pkg.sv
// Types, constants and helper functions of the tuning command parser.
package utcp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Stored tuning values; target and base are two's complement.
    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] target;
        logic [15:0] base;
    } t_stores;

    // One command from the front part to the back part.
    typedef struct packed {
        logic        echo;
        logic [7:0]  echo_byte;
        logic        ack;
        t_stores     stores;
    } t_cmd;

    typedef enum logic [2:0] {
        SEL_NONE   = 3'd0,
        SEL_KP     = 3'd1,
        SEL_KI     = 3'd2,
        SEL_KD     = 3'd3,
        SEL_TARGET = 3'd4,
        SEL_BASE   = 3'd5
    } t_sel;

    localparam logic [2:0] FIELD_KP     = 3'd0;
    localparam logic [2:0] FIELD_KI     = 3'd1;
    localparam logic [2:0] FIELD_KD     = 3'd2;
    localparam logic [2:0] FIELD_TARGET = 3'd3;
    localparam logic [2:0] FIELD_BASE   = 3'd4;

    // Decimal place of the leading digit of a 16-bit magnitude.
    localparam logic [2:0] DIGIT_TOP = 3'd4;

    localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd5;
    localparam t_stores     STORES_RESET     = '{
        kp: 16'd25, ki: 16'd8, kd: 16'd0, target: 16'd42, base: 16'd800
    };

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    // Upper-case hex character of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'b0, nib};
        end
        return 8'h37 + {4'b0, nib};
    endfunction

    // Weight of a decimal place.
    function automatic logic [16:0] pow10(input logic [2:0] pos);
        case (pos)
            3'd0: return 17'd1;
            3'd1: return 17'd10;
            3'd2: return 17'd100;
            3'd3: return 17'd1000;
            default: return 17'd10000;
        endcase
    endfunction

    // Letter that opens each field of the acknowledge line.
    function automatic logic [7:0] field_letter(input logic [2:0] field);
        case (field)
            FIELD_KP:     return CH_P;
            FIELD_KI:     return CH_I;
            FIELD_KD:     return CH_D;
            FIELD_TARGET: return CH_T;
            default:      return CH_B;
        endcase
    endfunction

endpackage

FILE: hw/rtl/uart_tuning_command_parser.sv
// Top level of the UART tuning command parser.
// Input channel: one beat per UART event. i_mode low carries a received byte in
// i_rx_byte with its error flag i_rx_error; i_mode high is an idle poll tick.
// Output channel: one beat per byte to transmit on o_tx_byte, with o_last set on
// the final beat caused by an input beat, and the five stored tuning values on
// every beat. A good byte is echoed as '<HH>'; a line ended by CR, LF or the
// idle timeout with a parameter letter seen stores the value and adds the line
// "P.. I.. D.. T.. B..\r\n". Beats that cause nothing give no output beats.
// The first output beat of an input beat passes the command queue, the command
// register of the sequencer and the output register. The sequencer takes each
// echo character, letter, sign, space and line end, and each decimal place (five
// per value, leading zeros suppressed), as a step of its own after a step to
// fetch the command, and so sets the rate; an output stall holds it.
// A two-entry command queue sits between the parser and the sequencer, so the
// parser keeps taking input beats while the sequencer works or the receiver
// stalls; o_in_ready falls only when that queue is full. A stalled output beat
// is held in the output register. Reset (synchronous, active low) empties the
// queue and output, clears the line, and restores the default values and an
// idle limit of 5. i_cfg_we writes the idle limit from i_cfg_wdata.
module uart_tuning_command_parser #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_rx_error,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last,
    output logic [15:0]        o_kp_code,
    output logic [15:0]        o_ki_code,
    output logic [15:0]        o_kd_code,
    output logic signed [15:0] o_target_speed,
    output logic signed [15:0] o_base_duty
);

    // Commands from the parser: echo byte, acknowledge flag and value snapshot.
    logic              w_push;
    utcp_pkg::t_cmd    w_push_data;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    utcp_pkg::t_cmd    w_pop_data;
    utcp_pkg::t_stores w_stores;

    utcp_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .i_rx_error   (i_rx_error),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    utcp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_pop_data  (w_pop_data)
    );

    // The sequencer owns the output register that parts it from the receiver.
    utcp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (w_empty),
        .i_queue_data  (w_pop_data),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_stores      (w_stores)
    );

    assign o_kp_code      = w_stores.kp;
    assign o_ki_code      = w_stores.ki;
    assign o_kd_code      = w_stores.kd;
    assign o_target_speed = signed'(w_stores.target);
    assign o_base_duty    = signed'(w_stores.base);

endmodule

FILE: hw/rtl/utcp_queue.sv
// Short command queue between the line parser and the transmit sequencer.
module utcp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utcp_pkg::t_cmd  i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output utcp_pkg::t_cmd  o_pop_data
);

    utcp_pkg::t_cmd                 r_mem [utcp_pkg::QUEUE_DEPTH];
    logic [utcp_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [utcp_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [utcp_pkg::QUEUE_AW:0]    r_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_full     = (r_count == (utcp_pkg::QUEUE_AW + 1)'(utcp_pkg::QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/utcp_front.sv
// Line parser: takes byte and idle-tick beats, keeps line state and stored values.
module utcp_front #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_mode,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_rx_error,
    input  logic            i_queue_full,
    output logic            o_push,
    output utcp_pkg::t_cmd  o_push_data
);

    localparam int LW = $clog2(LINE_CAPACITY);
    localparam logic [LW-1:0] LINE_LIMIT = LW'(LINE_CAPACITY - 1);

    logic [7:0]        r_idle_limit;
    logic [LW-1:0]     r_line_count, n_line_count;
    logic [7:0]        r_idle_count, n_idle_count;
    utcp_pkg::t_sel    r_sel, n_sel;
    logic [15:0]       r_acc, n_acc;
    utcp_pkg::t_stores r_stores, n_stores;

    logic        w_accept;
    logic        w_echo;
    logic        w_ack;
    logic        w_close;
    logic        w_close_term;
    logic        w_is_digit;
    logic [7:0]  w_upper;
    logic [19:0] w_acc_ext;
    logic [15:0] w_acc_digit;

    assign o_in_ready  = !i_queue_full;
    assign w_accept    = i_in_valid && !i_queue_full;
    assign w_is_digit  = (i_rx_byte >= utcp_pkg::CH_ZERO) && (i_rx_byte <= utcp_pkg::CH_NINE);
    assign w_upper     = i_rx_byte & utcp_pkg::CASE_MASK;
    // Digits carry their value in the low nibble.
    assign w_acc_ext   = 20'(r_acc) * 20'd10 + 20'(i_rx_byte[3:0]);
    assign w_acc_digit = (w_acc_ext[19:16] != 4'd0) ? 16'hFFFF : w_acc_ext[15:0];

    always_comb begin
        n_line_count = r_line_count;
        n_idle_count = r_idle_count;
        n_sel        = r_sel;
        n_acc        = r_acc;
        n_stores     = r_stores;
        w_echo       = 1'b0;
        w_ack        = 1'b0;
        w_close      = 1'b0;
        w_close_term = 1'b0;

        if (w_accept) begin
            if (!i_mode) begin
                n_idle_count = 8'd0;
                if (i_rx_error) begin
                    n_line_count = '0;
                    n_sel        = utcp_pkg::SEL_NONE;
                    n_acc        = 16'd0;
                end else begin
                    w_echo = 1'b1;
                    if (r_line_count < LINE_LIMIT) begin
                        n_line_count = r_line_count + 1'b1;
                        if (i_rx_byte == utcp_pkg::CH_CR || i_rx_byte == utcp_pkg::CH_LF) begin
                            w_close      = 1'b1;
                            w_close_term = 1'b1;
                        end else if (w_is_digit) begin
                            n_acc = w_acc_digit;
                        end else if (w_upper == utcp_pkg::CH_P) begin
                            n_sel = utcp_pkg::SEL_KP;
                            n_acc = 16'd0;
                        end else if (w_upper == utcp_pkg::CH_I) begin
                            n_sel = utcp_pkg::SEL_KI;
                            n_acc = 16'd0;
                        end else if (w_upper == utcp_pkg::CH_D) begin
                            n_sel = utcp_pkg::SEL_KD;
                            n_acc = 16'd0;
                        end else if (w_upper == utcp_pkg::CH_T) begin
                            n_sel = utcp_pkg::SEL_TARGET;
                            n_acc = 16'd0;
                        end else if (w_upper == utcp_pkg::CH_B) begin
                            n_sel = utcp_pkg::SEL_BASE;
                            n_acc = 16'd0;
                        end
                    end else begin
                        // The line is full: the byte is echoed and the line dropped.
                        n_line_count = '0;
                        n_sel        = utcp_pkg::SEL_NONE;
                        n_acc        = 16'd0;
                    end
                end
            end else if (r_line_count != '0) begin
                if (r_idle_count != 8'hFF) begin
                    n_idle_count = r_idle_count + 8'd1;
                end
                if (n_idle_count >= r_idle_limit) begin
                    w_close      = 1'b1;
                    w_close_term = (r_line_count < LINE_LIMIT);
                end
            end

            if (w_close) begin
                if (w_close_term && r_sel != utcp_pkg::SEL_NONE) begin
                    w_ack = 1'b1;
                    case (r_sel)
                        utcp_pkg::SEL_KP:     n_stores.kp     = r_acc;
                        utcp_pkg::SEL_KI:     n_stores.ki     = r_acc;
                        utcp_pkg::SEL_KD:     n_stores.kd     = r_acc;
                        utcp_pkg::SEL_TARGET: n_stores.target = r_acc;
                        default:              n_stores.base   = r_acc;
                    endcase
                end
                n_line_count = '0;
                n_sel        = utcp_pkg::SEL_NONE;
                n_acc        = 16'd0;
                n_idle_count = 8'd0;
            end
        end
    end

    assign o_push                = w_accept && (w_echo || w_ack);
    assign o_push_data.echo      = w_echo;
    assign o_push_data.echo_byte = i_rx_byte;
    assign o_push_data.ack       = w_ack;
    assign o_push_data.stores    = n_stores;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= utcp_pkg::IDLE_LIMIT_RESET;
            r_line_count <= '0;
            r_idle_count <= 8'd0;
            r_sel        <= utcp_pkg::SEL_NONE;
            r_acc        <= 16'd0;
            r_stores     <= utcp_pkg::STORES_RESET;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            r_line_count <= n_line_count;
            r_idle_count <= n_idle_count;
            r_sel        <= n_sel;
            r_acc        <= n_acc;
            r_stores     <= n_stores;
        end
    end

endmodule

FILE: hw/rtl/utcp_back.sv
// Transmit sequencer: turns queued commands into hex echo and decimal acknowledge bytes.
module utcp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_queue_empty,
    input  utcp_pkg::t_cmd     i_queue_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last,
    output utcp_pkg::t_stores  o_stores
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ECHO   = 8'b0000_0010,
        S_LETTER = 8'b0000_0100,
        S_SIGN   = 8'b0000_1000,
        S_DIGIT  = 8'b0001_0000,
        S_SPACE  = 8'b0010_0000,
        S_CR     = 8'b0100_0000,
        S_LF     = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    utcp_pkg::t_cmd    r_cmd;
    logic [1:0]        r_echo_idx, n_echo_idx;
    logic [2:0]        r_field, n_field;
    logic [16:0]       r_value, n_value;
    logic [2:0]        r_pos, n_pos;
    logic              r_started, n_started;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    utcp_pkg::t_stores r_out_stores;

    logic [15:0] w_field_raw;
    logic        w_field_neg;
    logic [16:0] w_field_mag;
    logic [16:0] w_place;
    logic [3:0]  w_dig;
    logic [16:0] w_sub;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_out_free;
    logic        w_step;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop      = (r_state == S_IDLE) && !i_queue_empty;

    always_comb begin
        case (r_field)
            utcp_pkg::FIELD_KP:     w_field_raw = r_cmd.stores.kp;
            utcp_pkg::FIELD_KI:     w_field_raw = r_cmd.stores.ki;
            utcp_pkg::FIELD_KD:     w_field_raw = r_cmd.stores.kd;
            utcp_pkg::FIELD_TARGET: w_field_raw = r_cmd.stores.target;
            default:                w_field_raw = r_cmd.stores.base;
        endcase
    end

    assign w_field_neg = (r_field == utcp_pkg::FIELD_TARGET || r_field == utcp_pkg::FIELD_BASE)
                         && w_field_raw[15];
    assign w_field_mag = w_field_neg ? (17'h10000 - {1'b0, w_field_raw}) : {1'b0, w_field_raw};

    // One decimal digit per step: compare against the nine multiples of the place.
    assign w_place = utcp_pkg::pow10(r_pos);
    always_comb begin
        w_dig = 4'd0;
        w_sub = 17'd0;
        for (int k = 1; k < 10; k++) begin
            if (r_value >= 17'(k) * w_place) begin
                w_dig = 4'(k);
                w_sub = 17'(k) * w_place;
            end
        end
    end

    always_comb begin
        w_emit = 1'b0;
        w_byte = utcp_pkg::CH_SPACE;
        w_last = 1'b0;
        case (r_state)
            S_ECHO: begin
                w_emit = 1'b1;
                case (r_echo_idx)
                    2'd0:    w_byte = utcp_pkg::CH_LT;
                    2'd1:    w_byte = utcp_pkg::hex_char(r_cmd.echo_byte[7:4]);
                    2'd2:    w_byte = utcp_pkg::hex_char(r_cmd.echo_byte[3:0]);
                    default: w_byte = utcp_pkg::CH_GT;
                endcase
                w_last = (r_echo_idx == 2'd3) && !r_cmd.ack;
            end
            S_LETTER: begin
                w_emit = 1'b1;
                w_byte = utcp_pkg::field_letter(r_field);
            end
            S_SIGN: begin
                w_emit = 1'b1;
                w_byte = utcp_pkg::CH_MINUS;
            end
            S_DIGIT: begin
                w_emit = r_started || (w_dig != 4'd0) || (r_pos == 3'd0);
                w_byte = utcp_pkg::CH_ZERO + {4'b0, w_dig};
            end
            S_SPACE: begin
                w_emit = 1'b1;
                w_byte = utcp_pkg::CH_SPACE;
            end
            S_CR: begin
                w_emit = 1'b1;
                w_byte = utcp_pkg::CH_CR;
            end
            S_LF: begin
                w_emit = 1'b1;
                w_byte = utcp_pkg::CH_LF;
                w_last = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign w_step = (r_state != S_IDLE) && (!w_emit || w_out_free);

    always_comb begin
        n_state    = r_state;
        n_echo_idx = r_echo_idx;
        n_field    = r_field;
        n_value    = r_value;
        n_pos      = r_pos;
        n_started  = r_started;
        if (r_state == S_IDLE) begin
            if (!i_queue_empty) begin
                n_state    = i_queue_data.echo ? S_ECHO : S_LETTER;
                n_echo_idx = 2'd0;
                n_field    = utcp_pkg::FIELD_KP;
            end
        end else if (w_step) begin
            case (r_state)
                S_ECHO: begin
                    if (r_echo_idx == 2'd3) begin
                        n_state = r_cmd.ack ? S_LETTER : S_IDLE;
                    end
                    n_echo_idx = r_echo_idx + 2'd1;
                end
                S_LETTER: begin
                    n_value   = w_field_mag;
                    n_pos     = utcp_pkg::DIGIT_TOP;
                    n_started = 1'b0;
                    n_state   = w_field_neg ? S_SIGN : S_DIGIT;
                end
                S_SIGN: begin
                    n_state = S_DIGIT;
                end
                S_DIGIT: begin
                    n_value   = r_value - w_sub;
                    n_started = r_started || (w_dig != 4'd0);
                    n_pos     = r_pos - 3'd1;
                    if (r_pos == 3'd0) begin
                        n_state = (r_field == utcp_pkg::FIELD_BASE) ? S_CR : S_SPACE;
                    end
                end
                S_SPACE: begin
                    n_field = r_field + 3'd1;
                    n_state = S_LETTER;
                end
                S_CR: begin
                    n_state = S_LF;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_queue_data;
        end
        r_echo_idx <= n_echo_idx;
        r_field    <= n_field;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_started  <= n_started;
        if (w_step && w_emit) begin
            r_out_byte   <= w_byte;
            r_out_last   <= w_last;
            r_out_stores <= r_cmd.stores;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last      = r_out_last;
    assign o_stores    = r_out_stores;

endmodule

FILE: hw/rtl/utcp_checker.sv
// Port-level checker of the tuning command parser and its bind statement.
`include "uart_tuning_command_parser_assert.svh"

module utcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_last
);

    // A stalled output beat stays offered with the same byte.
    `UTCP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_tx_byte) && $stable(o_last), "output beat changed while stalled")

    // Every run of output beats ends on the closing bracket of the echo or on LF.
    `UTCP_ASSERT_NOW(a_last_char, o_out_valid && o_last, o_tx_byte == utcp_pkg::CH_GT || o_tx_byte == utcp_pkg::CH_LF, "last beat is not '>' or LF")

    // A raw LF is only sent as the end of an acknowledge line.
    `UTCP_ASSERT_NOW(a_lf_last, o_out_valid && o_tx_byte == utcp_pkg::CH_LF, o_last, "LF sent without last")

    // An echo never ends on its opening bracket.
    `UTCP_ASSERT_NOW(a_open_not_last, o_out_valid && o_tx_byte == utcp_pkg::CH_LT, !o_last, "'<' flagged as last")

endmodule

bind uart_tuning_command_parser utcp_checker u_utcp_checker (.*);
